// ===== hw/rtl/im2col_pkg.sv =====
// im2col_pkg: shared widths and register indexes for the im2col unfold unit.
// No dependencies; imported by im2col_unfold_unit.
package im2col_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD          = 3'd5;

    // field widths
    localparam int WORD_W  = 32;
    localparam int WADDR_W = 12;
    localparam int POS_W   = 30;

    // padded extent, column-matrix extent and the divider over it
    localparam int EXT_W     = 10;
    localparam int DIV_STEPS = EXT_W;
    localparam int DCNT_W    = 4;

    // derived products
    localparam int LIMIT_W = 25;   // channels * height * width
    localparam int FLAT_W  = 25;   // flat image address of a read
    localparam int KIDX_W  = 14;   // kernel-row index of the column matrix
    localparam int P1_W    = 24;

endpackage

// ===== hw/rtl/im2col_unfold_unit.sv =====
// im2col_unfold_unit: image buffer with an im2col unfold read port.
// Uses im2col_pkg and im2col_ram.
//
// One item at a time. A write item (func 0) goes from state S_A to S_OUT, where
// its result is offered; a read item (func 1) passes through index arithmetic
// in states S_A to S_D (one multiply per path per cycle), the last of which
// launches the registered read of the image RAM, whose data is taken into the
// output register in S_OUT. The next item is accepted the cycle after the
// previous one has been handed to the output register, even while that result
// still waits to be taken. A stalled output holds the unit until its result is
// taken. After reset and after every configuration write the unit is busy
// (in_ready low) while a bit-serial divider works out the column-matrix extents
// (one quotient bit a cycle) and the write limit channels*height*width. Reads
// of image words never written return undefined data.
module im2col_unfold_unit #(
    parameter int IMAGE_DEPTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [11:0]                       write_address,
    input  logic [31:0]                       write_value,
    input  logic [5:0]                        chan,
    input  logic [3:0]                        kernel_row,
    input  logic [3:0]                        kernel_col,
    input  logic [7:0]                        out_row,
    input  logic [7:0]                        out_col,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       value,
    output logic                              in_padding,
    output logic [29:0]                       col_position,
    output logic                              bad_request
);

    import im2col_pkg::*;

    localparam int AW = $clog2(IMAGE_DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(IMAGE_DEPTH);

    typedef enum logic [3:0] {
        S_PREP_LOAD,
        S_PREP_DIV,
        S_PREP_DONE,
        S_IDLE,
        S_A,
        S_B,
        S_C,
        S_D,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [6:0] channels_reg;
    logic [8:0] height_reg;
    logic [8:0] width_reg;
    logic [3:0] ksize_reg;
    logic [3:0] step_reg;
    logic [2:0] pad_reg;

    // derived geometry
    logic [EXT_W-1:0]   col_h_reg;
    logic [EXT_W-1:0]   col_w_reg;
    logic [15:0]        ch_h_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [EXT_W-1:0]   dq_h_reg;
    logic [EXT_W-1:0]   dq_w_reg;
    logic [3:0]         rem_h_reg;
    logic [3:0]         rem_w_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;

    // latched item
    logic               func_reg;
    logic [11:0]        waddr_reg;
    logic [31:0]        wvalue_reg;
    logic [5:0]         chan_reg;
    logic [3:0]         krow_reg;
    logic [3:0]         kcol_reg;
    logic [7:0]         orow_reg;
    logic [7:0]         ocol_reg;

    // read datapath
    logic [11:0]        row_u_reg;
    logic [11:0]        col_u_reg;
    logic [9:0]         ck_reg;
    logic [14:0]        hch_reg;
    logic               geo_bad_reg;
    logic [KIDX_W-1:0]  kidx_reg;
    logic               pad_hit_reg;
    logic [14:0]        rowidx_reg;
    logic [8:0]         icol_reg;
    logic [P1_W-1:0]    p1_reg;
    logic [FLAT_W-1:0]  flat_reg;

    // pending result
    logic               res_bad_reg;
    logic               res_pad_reg;
    logic [POS_W-1:0]   res_pos_reg;
    logic               res_use_ram_reg;

    // output register
    logic               out_valid_reg;
    logic [31:0]        value_reg;
    logic               in_padding_reg;
    logic [POS_W-1:0]   col_position_reg;
    logic               bad_request_reg;

    logic [31:0]        ram_rdata;
    logic               ram_we;
    logic               ram_re;

    logic               accept;
    logic               load_out;
    logic [EXT_W-1:0]   padded_h;
    logic [EXT_W-1:0]   padded_w;
    logic               fit_h;
    logic               fit_w;
    logic [4:0]         shift_h;
    logic [4:0]         shift_w;
    logic               ge_h;
    logic               ge_w;
    logic               cfg_zero;
    logic               write_bad;
    logic signed [12:0] irow;
    logic signed [12:0] icol;
    logic               flat_bad;
    logic [POS_W-1:0]   pos;

    assign in_ready = (state_reg == S_IDLE) && !cfg_wr_en;
    assign accept   = in_valid && in_ready;

    // pending result moves into the output register this cycle
    assign load_out = (state_reg == S_OUT) && !cfg_wr_en && (!out_valid_reg || out_ready);

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign in_padding   = in_padding_reg;
    assign col_position = col_position_reg;
    assign bad_request  = bad_request_reg;

    // padded image extents; kernel must fit for a non-empty column matrix
    assign padded_h = EXT_W'(height_reg) + EXT_W'({pad_reg, 1'b0});
    assign padded_w = EXT_W'(width_reg) + EXT_W'({pad_reg, 1'b0});
    assign fit_h    = padded_h >= EXT_W'(ksize_reg);
    assign fit_w    = padded_w >= EXT_W'(ksize_reg);

    // restoring divider step, one quotient bit a cycle for each extent
    assign shift_h = {rem_h_reg, dq_h_reg[EXT_W-1]};
    assign shift_w = {rem_w_reg, dq_w_reg[EXT_W-1]};
    assign ge_h    = shift_h >= {1'b0, step_reg};
    assign ge_w    = shift_w >= {1'b0, step_reg};

    assign cfg_zero = (channels_reg == '0) || (height_reg == '0) || (width_reg == '0) ||
                      (ksize_reg == '0) || (step_reg == '0);

    assign write_bad = (32'(waddr_reg) >= DEPTH_W) || (LIMIT_W'(waddr_reg) >= limit_reg);

    // signed image coordinate; negative means top or left border
    assign irow = $signed({1'b0, row_u_reg}) - $signed({10'd0, pad_reg});
    assign icol = $signed({1'b0, col_u_reg}) - $signed({10'd0, pad_reg});

    assign flat_bad = 32'(flat_reg) >= DEPTH_W;
    assign pos      = POS_W'(p1_reg * col_w_reg + ocol_reg);

    assign ram_we = (state_reg == S_A) && !func_reg && !write_bad;
    assign ram_re = (state_reg == S_D) && !geo_bad_reg && !pad_hit_reg && !flat_bad;

    im2col_ram #(
        .WIDTH (WORD_W),
        .DEPTH (IMAGE_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(waddr_reg)),
        .wdata (wvalue_reg),
        .re    (ram_re),
        .raddr (AW'(flat_reg)),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= 7'd1;
            height_reg   <= 9'd8;
            width_reg    <= 9'd8;
            ksize_reg    <= 4'd3;
            step_reg     <= 4'd1;
            pad_reg      <= 3'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CHANNELS:     channels_reg <= cfg_data[6:0];
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[8:0];
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[8:0];
                CFG_KERNEL_SIZE:  ksize_reg    <= cfg_data[3:0];
                CFG_STEP:         step_reg     <= cfg_data[3:0];
                CFG_PAD:          pad_reg      <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_PREP_LOAD;
            out_valid_reg    <= 1'b0;
            value_reg        <= '0;
            in_padding_reg   <= 1'b0;
            col_position_reg <= '0;
            bad_request_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                state_reg <= S_PREP_LOAD;
            end
            else
            begin
                case (state_reg)
                    S_PREP_LOAD:
                    begin
                        state_reg <= S_PREP_DIV;
                    end
                    S_PREP_DIV:
                    begin
                        if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                        begin
                            state_reg <= S_PREP_DONE;
                        end
                    end
                    S_PREP_DONE:
                    begin
                        state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            state_reg <= S_A;
                        end
                    end
                    S_A:
                    begin
                        state_reg <= func_reg ? S_B : S_OUT;
                    end
                    S_B:
                    begin
                        state_reg <= S_C;
                    end
                    S_C:
                    begin
                        state_reg <= S_D;
                    end
                    S_D:
                    begin
                        state_reg <= S_OUT;
                    end
                    S_OUT:
                    begin
                        if (load_out)
                        begin
                            out_valid_reg    <= 1'b1;
                            value_reg        <= res_use_ram_reg ? ram_rdata : '0;
                            in_padding_reg   <= res_pad_reg;
                            col_position_reg <= res_pos_reg;
                            bad_request_reg  <= res_bad_reg;
                            state_reg        <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_PREP_LOAD;
                    end
                endcase
            end
        end
    end

    // geometry precompute and item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_PREP_LOAD:
            begin
                dq_h_reg    <= padded_h - EXT_W'(ksize_reg);
                dq_w_reg    <= padded_w - EXT_W'(ksize_reg);
                rem_h_reg   <= '0;
                rem_w_reg   <= '0;
                div_cnt_reg <= '0;
                ch_h_reg    <= 16'(channels_reg * height_reg);
            end
            S_PREP_DIV:
            begin
                rem_h_reg   <= ge_h ? 4'(shift_h - {1'b0, step_reg}) : shift_h[3:0];
                rem_w_reg   <= ge_w ? 4'(shift_w - {1'b0, step_reg}) : shift_w[3:0];
                dq_h_reg    <= {dq_h_reg[EXT_W-2:0], ge_h};
                dq_w_reg    <= {dq_w_reg[EXT_W-2:0], ge_w};
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == '0)
                begin
                    limit_reg <= LIMIT_W'(ch_h_reg * width_reg);
                end
            end
            S_PREP_DONE:
            begin
                col_h_reg <= fit_h ? dq_h_reg + 1'b1 : '0;
                col_w_reg <= fit_w ? dq_w_reg + 1'b1 : '0;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_reg   <= func;
                    waddr_reg  <= write_address;
                    wvalue_reg <= write_value;
                    chan_reg   <= chan;
                    krow_reg   <= kernel_row;
                    kcol_reg   <= kernel_col;
                    orow_reg   <= out_row;
                    ocol_reg   <= out_col;
                end
            end
            S_A:
            begin
                // write items finish here
                res_bad_reg     <= write_bad;
                res_pad_reg     <= 1'b0;
                res_pos_reg     <= '0;
                res_use_ram_reg <= 1'b0;
                row_u_reg   <= 12'(orow_reg * step_reg) + 12'(krow_reg);
                col_u_reg   <= 12'(ocol_reg * step_reg) + 12'(kcol_reg);
                ck_reg      <= 10'(chan_reg * ksize_reg) + 10'(krow_reg);
                hch_reg     <= 15'(height_reg * chan_reg);
                geo_bad_reg <= cfg_zero || ({1'b0, chan_reg} >= channels_reg) ||
                               (krow_reg >= ksize_reg) || (kcol_reg >= ksize_reg) ||
                               (EXT_W'(orow_reg) >= col_h_reg) ||
                               (EXT_W'(ocol_reg) >= col_w_reg);
            end
            S_B:
            begin
                kidx_reg    <= KIDX_W'(ck_reg * ksize_reg) + KIDX_W'(kcol_reg);
                pad_hit_reg <= (irow < 0) || (icol < 0) ||
                               (irow >= $signed({4'd0, height_reg})) ||
                               (icol >= $signed({4'd0, width_reg}));
                rowidx_reg  <= hch_reg + 15'(irow[8:0]);
                icol_reg    <= icol[8:0];
            end
            S_C:
            begin
                p1_reg   <= P1_W'(kidx_reg * col_h_reg) + P1_W'(orow_reg);
                flat_reg <= FLAT_W'(rowidx_reg * width_reg) + FLAT_W'(icol_reg);
            end
            S_D:
            begin
                // order of precedence: bad coordinates, border, store overrun
                if (geo_bad_reg)
                begin
                    res_bad_reg     <= 1'b1;
                    res_pad_reg     <= 1'b0;
                    res_pos_reg     <= '0;
                    res_use_ram_reg <= 1'b0;
                end
                else if (pad_hit_reg)
                begin
                    res_bad_reg     <= 1'b0;
                    res_pad_reg     <= 1'b1;
                    res_pos_reg     <= pos;
                    res_use_ram_reg <= 1'b0;
                end
                else if (flat_bad)
                begin
                    res_bad_reg     <= 1'b1;
                    res_pad_reg     <= 1'b0;
                    res_pos_reg     <= '0;
                    res_use_ram_reg <= 1'b0;
                end
                else
                begin
                    res_bad_reg     <= 1'b0;
                    res_pad_reg     <= 1'b0;
                    res_pos_reg     <= pos;
                    res_use_ram_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/im2col_ram.sv =====
// im2col_ram: generic single-write, single-read synchronous RAM.
// Read data registered. No dependencies.
module im2col_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/im2col_unfold_unit_tb.sv =====
`timescale 1ns / 100ps
// im2col_unfold_unit_tb: self-checking testbench for the im2col unfold unit.
// Depends on im2col_pkg and im2col_unfold_unit; predicts every result in place.
module im2col_unfold_unit_tb;

    import im2col_pkg::*;

    localparam int STORE_DEPTH    = 4096;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [1:0] {RD_BAD, RD_PADDING, RD_IMAGE} read_kind_t;

    typedef struct packed {
        logic        func;
        logic [11:0] write_address;
        logic [31:0] write_value;
        logic [5:0]  chan;
        logic [3:0]  kernel_row;
        logic [3:0]  kernel_col;
        logic [7:0]  out_row;
        logic [7:0]  out_col;
    } unfold_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        in_padding;
        logic [29:0] col_position;
        logic        bad_request;
    } unfold_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = 1'b0;
    logic [11:0]           write_address = '0;
    logic [31:0]           write_value = '0;
    logic [5:0]            chan = '0;
    logic [3:0]            kernel_row = '0;
    logic [3:0]            kernel_col = '0;
    logic [7:0]            out_row = '0;
    logic [7:0]            out_col = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [31:0]           value;
    logic                  in_padding;
    logic [29:0]           col_position;
    logic                  bad_request;

    // shadow of the register file, at reset values
    longint unsigned cfg_channels = 1;
    longint unsigned cfg_height   = 8;
    longint unsigned cfg_width    = 8;
    longint unsigned cfg_kernel   = 3;
    longint unsigned cfg_step     = 1;
    longint unsigned cfg_pad      = 0;

    logic [31:0] image_shadow  [STORE_DEPTH];
    bit          image_written [STORE_DEPTH];

    unfold_res_t expected_results[$];

    bit steady = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_padding = 0;
    int n_bad = 0;
    int n_settings = 1;

    im2col_unfold_unit #(
        .IMAGE_DEPTH(STORE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .write_address(write_address),
        .write_value  (write_value),
        .chan         (chan),
        .kernel_row   (kernel_row),
        .kernel_col   (kernel_col),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .in_padding   (in_padding),
        .col_position (col_position),
        .bad_request  (bad_request)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned col_extent(input longint unsigned size);
        longint unsigned padded;
        padded = size + 2 * cfg_pad;
        if (cfg_step == 0 || padded < cfg_kernel)
            return 0;
        return (padded - cfg_kernel) / cfg_step + 1;
    endfunction

    function automatic read_kind_t classify_read(input unfold_req_t r,
                                                 output longint unsigned pos,
                                                 output longint unsigned addr);
        longint unsigned col_h, col_w;
        longint irow, icol;
        pos = 0;
        addr = 0;
        if (cfg_channels == 0 || cfg_height == 0 || cfg_width == 0 ||
            cfg_kernel == 0 || cfg_step == 0)
            return RD_BAD;
        col_h = col_extent(cfg_height);
        col_w = col_extent(cfg_width);
        if (r.chan >= cfg_channels || r.kernel_row >= cfg_kernel ||
            r.kernel_col >= cfg_kernel || r.out_row >= col_h || r.out_col >= col_w)
            return RD_BAD;
        pos = ((r.chan * cfg_kernel * cfg_kernel + r.kernel_row * cfg_kernel + r.kernel_col)
               * col_h + r.out_row) * col_w + r.out_col;
        irow = longint'(r.kernel_row + r.out_row * cfg_step) - longint'(cfg_pad);
        icol = longint'(r.kernel_col + r.out_col * cfg_step) - longint'(cfg_pad);
        if (irow < 0 || icol < 0 || irow >= longint'(cfg_height) ||
            icol >= longint'(cfg_width))
            return RD_PADDING;
        addr = longint'(icol) + cfg_width * (longint'(irow) + cfg_height * r.chan);
        if (addr >= STORE_DEPTH)
        begin
            pos = 0;
            return RD_BAD;
        end
        return RD_IMAGE;
    endfunction

    function automatic unfold_res_t predict_result(input unfold_req_t r);
        unfold_res_t res;
        longint unsigned pos, addr;
        read_kind_t kind;
        res = '0;
        if (r.func == FUNC_WRITE)
        begin
            n_writes++;
            if (r.write_address >= STORE_DEPTH ||
                r.write_address >= cfg_channels * cfg_height * cfg_width)
            begin
                res.bad_request = 1'b1;
                n_bad++;
            end
            else
            begin
                image_shadow[r.write_address]  = r.write_value;
                image_written[r.write_address] = 1'b1;
            end
            return res;
        end
        n_reads++;
        kind = classify_read(r, pos, addr);
        case (kind)
            RD_BAD:
            begin
                res.bad_request = 1'b1;
                n_bad++;
            end
            RD_PADDING:
            begin
                res.in_padding   = 1'b1;
                res.col_position = pos[29:0];
                n_padding++;
            end
            default:
            begin
                res.value        = image_shadow[addr];
                res.col_position = pos[29:0];
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // item construction and driving
    // ------------------------------------------------------------------
    function automatic unfold_req_t make_write(input logic [11:0] addr,
                                               input logic [31:0] data);
        unfold_req_t r;
        r.func          = FUNC_WRITE;
        r.write_address = addr;
        r.write_value   = data;
        r.chan          = 6'($urandom());
        r.kernel_row    = 4'($urandom());
        r.kernel_col    = 4'($urandom());
        r.out_row       = 8'($urandom());
        r.out_col       = 8'($urandom());
        return r;
    endfunction

    function automatic unfold_req_t make_read(input logic [5:0] c, input logic [3:0] kr,
                                              input logic [3:0] kc, input logic [7:0] orow,
                                              input logic [7:0] ocol);
        unfold_req_t r;
        r.func          = FUNC_READ;
        r.write_address = 12'($urandom());
        r.write_value   = $urandom();
        r.chan          = c;
        r.kernel_row    = kr;
        r.kernel_col    = kc;
        r.out_row       = orow;
        r.out_col       = ocol;
        return r;
    endfunction

    task automatic issue(input unfold_req_t r);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= r.func;
        write_address <= r.write_address;
        write_value   <= r.write_value;
        chan          <= r.chan;
        kernel_row    <= r.kernel_row;
        kernel_col    <= r.kernel_col;
        out_row       <= r.out_row;
        out_col       <= r.out_col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_result(r));
    endtask

    // a read never lands on a store word that has not been written yet
    task automatic send_item(input unfold_req_t r);
        longint unsigned pos, addr;
        read_kind_t kind;
        if (r.func == FUNC_READ)
        begin
            kind = classify_read(r, pos, addr);
            if (kind == RD_IMAGE && !image_written[addr])
                issue(make_write(addr[11:0], $urandom()));
        end
        issue(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_CHANNELS:     cfg_channels = data[6:0];
            CFG_IMAGE_HEIGHT: cfg_height   = data[8:0];
            CFG_IMAGE_WIDTH:  cfg_width    = data[8:0];
            CFG_KERNEL_SIZE:  cfg_kernel   = data[3:0];
            CFG_STEP:         cfg_step     = data[3:0];
            CFG_PAD:          cfg_pad      = data[2:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [8:0] ch, input logic [8:0] h,
                                input logic [8:0] w, input logic [8:0] k,
                                input logic [8:0] s, input logic [8:0] p);
        wait_drained();
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_KERNEL_SIZE, k);
        write_reg(CFG_STEP, s);
        write_reg(CFG_PAD, p);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // 1 channel, 8x8, K 3, step 1, no pad: limit 64, 6x6 column matrix
        send_item(make_write(12'd0, 32'hFFFF_FFFF));
        send_item(make_write(12'd63, 32'h0000_0000));
        send_item(make_write(12'd64, 32'h5A5A_A5A5));
        send_item(make_write(12'd4095, 32'hA5A5_5A5A));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        send_item(make_read(6'd0, 4'd2, 4'd2, 8'd5, 8'd5));
        send_item(make_read(6'd1, 4'd0, 4'd0, 8'd0, 8'd0));
        send_item(make_read(6'd0, 4'd3, 4'd0, 8'd0, 8'd0));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd6, 8'd0));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd6));
    endtask

    task automatic test_padding_borders();
        set_geometry(9'd2, 9'd4, 9'd5, 9'd3, 9'd2, 9'd1);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));   // top-left border
        send_item(make_read(6'd1, 4'd2, 4'd2, 8'd1, 8'd2));   // right border
        send_item(make_read(6'd1, 4'd2, 4'd0, 8'd1, 8'd0));   // left border
        send_item(make_read(6'd1, 4'd1, 4'd1, 8'd1, 8'd1));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd1, 8'd2));
    endtask

    task automatic test_zero_geometry();
        set_geometry(9'd0, 9'd8, 9'd8, 9'd3, 9'd1, 9'd0);
        send_item(make_write(12'd0, $urandom()));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        set_geometry(9'd1, 9'd0, 9'd8, 9'd3, 9'd1, 9'd0);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        set_geometry(9'd1, 9'd8, 9'd0, 9'd3, 9'd1, 9'd0);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        set_geometry(9'd1, 9'd8, 9'd8, 9'd0, 9'd1, 9'd0);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        set_geometry(9'd1, 9'd8, 9'd8, 9'd3, 9'd0, 9'd0);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
    endtask

    task automatic test_kernel_exceeds_image();
        set_geometry(9'd1, 9'd1, 9'd1, 9'd15, 9'd1, 9'd0);
        send_item(make_write(12'd0, $urandom()));
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        set_geometry(9'd1, 9'd2, 9'd2, 9'd7, 9'd1, 9'd2);
        send_item(make_read(6'd0, 4'd0, 4'd0, 8'd0, 8'd0));
    endtask

    task automatic test_register_overrange();
        // all bits set; step keeps 1 after masking so the index wraps past 30 bits
        set_geometry(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1F1, 9'h1FF);
        send_item(make_read(6'd63, 4'd0, 4'd14, 8'd0, 8'd255));
        send_item(make_read(6'd63, 4'd14, 4'd14, 8'd255, 8'd255));
        send_item(make_read(6'd0, 4'd7, 4'd7, 8'd0, 8'd0));
    endtask

    // n counts every item sent, the filler writes ahead of reads included
    task automatic run_random_phase(input int n, input bit no_gaps, input bit pause_midway);
        unfold_req_t r;
        longint unsigned limit, wr_top, col_h, col_w, ch_top;
        bit shaped;
        bit paused;
        int pick;
        int first;
        limit  = cfg_channels * cfg_height * cfg_width;
        wr_top = (limit < STORE_DEPTH) ? limit : STORE_DEPTH;
        col_h  = col_extent(cfg_height);
        col_w  = col_extent(cfg_width);
        shaped = cfg_channels != 0 && cfg_kernel != 0 && col_h != 0 && col_w != 0;
        if (col_h > 256)
            col_h = 256;
        if (col_w > 256)
            col_w = 256;
        ch_top = (cfg_channels > 64) ? 64 : cfg_channels;
        first  = n_writes + n_reads;
        paused = 1'b0;
        steady = no_gaps;
        while (n_writes + n_reads - first < n)
        begin
            if (pause_midway && !paused && n_writes + n_reads - first >= n / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25 && wr_top > 0)
                r = make_write(12'($urandom_range(0, 32'(wr_top - 1))), $urandom());
            else if (pick < 30)
                r = make_write(12'($urandom()), $urandom());
            else if (pick < 90 && shaped)
                r = make_read(6'($urandom_range(0, 32'(ch_top - 1))),
                              4'($urandom_range(0, 32'(cfg_kernel - 1))),
                              4'($urandom_range(0, 32'(cfg_kernel - 1))),
                              8'($urandom_range(0, 32'(col_h - 1))),
                              8'($urandom_range(0, 32'(col_w - 1))));
            else
                r = make_read(6'($urandom()), 4'($urandom()), 4'($urandom()),
                              8'($urandom()), 8'($urandom()));
            send_item(r);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_geometries();
        set_geometry(9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd0);
        run_random_phase(120, 1'b0, 1'b0);
        set_geometry(9'd64, 9'd256, 9'd256, 9'd15, 9'd15, 9'd7);
        run_random_phase(120, 1'b0, 1'b0);
        set_geometry(9'd4, 9'd16, 9'd16, 9'd3, 9'd1, 9'd1);
        run_random_phase(200, 1'b1, 1'b0);
        set_geometry(9'd3, 9'd10, 9'd12, 9'd5, 9'd2, 9'd2);
        run_random_phase(200, 1'b0, 1'b1);
        set_geometry(9'd1, 9'd64, 9'd64, 9'd7, 9'd3, 9'd3);
        run_random_phase(200, 1'b0, 1'b0);
        repeat (5)
        begin
            set_geometry(9'($urandom_range(1, 8)), 9'($urandom_range(1, 32)),
                         9'($urandom_range(1, 32)), 9'($urandom_range(1, 5)),
                         9'($urandom_range(1, 4)), 9'($urandom_range(0, 3)));
            run_random_phase(200, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin
        unfold_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, value);
                    errors++;
                end
                if (in_padding !== want.in_padding)
                begin
                    $error("in_padding: expected %b, got %b", want.in_padding, in_padding);
                    errors++;
                end
                if (col_position !== want.col_position)
                begin
                    $error("col_position: expected %h, got %h",
                           want.col_position, col_position);
                    errors++;
                end
                if (bad_request !== want.bad_request)
                begin
                    $error("bad_request: expected %b, got %b",
                           want.bad_request, bad_request);
                    errors++;
                end
            end
        end
    end

    // ends a hung run: counts cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_padding_borders();
        test_zero_geometry();
        test_kernel_exceeds_image();
        test_register_overrange();
        test_random_geometries();
        wait_drained();
        $display("covered %0d writes and %0d reads over %0d register settings",
                 n_writes, n_reads, n_settings);
        $display("of which %0d fell in the zero border and %0d were flagged bad",
                 n_padding, n_bad);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
